// ===== rtl/dft_pkg.sv =====
// ============================================================================
// dft_pkg: shared types, constants and helpers of the DShot frame transmitter
// Field widths, register indexes, the throttle mapping constants and small
// helpers used by the encoder and the waveform generator.
// ============================================================================
package dft_pkg;

    localparam int FRAME_BITS = 16;
    localparam int TICK_W     = 15;
    localparam int FRAC_W     = 17;
    localparam int VALUE_W    = 11;
    localparam int POS_W      = $clog2(FRAME_BITS + 1);
    localparam int BIT_IDX_W  = $clog2(FRAME_BITS);
    localparam int CFG_IDX_W  = 3;

    localparam logic [VALUE_W-1:0] THR_SCALE  = 11'd1999;
    localparam logic [VALUE_W-1:0] THR_OFFSET = 11'd48;
    localparam logic [15:0]        THR_FULL   = 16'd32768;
    localparam int                 THR_SHIFT  = 15;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ONE_HIGH  = 3'd0,
        CFG_ONE_LOW   = 3'd1,
        CFG_ZERO_HIGH = 3'd2,
        CFG_ZERO_LOW  = 3'd3,
        CFG_GAP       = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        MODE_TICK     = 1'b0,
        MODE_THROTTLE = 1'b1
    } t_mode;

    typedef enum logic {
        STATUS_OK    = 1'b0,
        STATUS_RANGE = 1'b1
    } t_status;

    typedef struct packed {
        logic [TICK_W-1:0] one_high;
        logic [TICK_W-1:0] one_low;
        logic [TICK_W-1:0] zero_high;
        logic [TICK_W-1:0] zero_low;
        logic [TICK_W-1:0] gap;
    } t_cfg;

    typedef struct packed {
        logic                  pin_level;
        logic [FRAME_BITS-1:0] frame_word;
        logic                  frame_end;
    } t_wave_out;

    // A count of zero behaves as one tick.
    function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
        return (v == '0) ? TICK_W'(1) : v;
    endfunction

    // Frame bit at position p, counted from the MSB.
    function automatic logic frame_bit(input logic [FRAME_BITS-1:0] frame,
                                       input logic [POS_W-1:0]      p);
        return frame[~p[BIT_IDX_W-1:0]];
    endfunction

endpackage

// ===== rtl/dft_if.sv =====
// ============================================================================
// dft_if: stream channels of the DShot frame transmitter
// Command channel (tick or throttle) and result channel, valid/ready.
// ============================================================================
interface dft_cmd_if
    import dft_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     mode;
    logic signed [FRAC_W-1:0] throttle_fraction;

    modport source (output valid, mode, throttle_fraction, input ready);
    modport sink   (input valid, mode, throttle_fraction, output ready);
endinterface

interface dft_res_if
    import dft_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic                  pin_level;
    logic                  status;
    logic [FRAME_BITS-1:0] frame_word;
    logic                  frame_end;

    modport source (output valid, pin_level, status, frame_word, frame_end, input ready);
    modport sink   (input valid, pin_level, status, frame_word, frame_end, output ready);
endinterface

// ===== rtl/dft_frame_enc.sv =====
// ============================================================================
// dft_frame_enc: throttle fraction to DShot frame
// Range check, scale to 48..2047, pack with telemetry bit and checksum.
// ============================================================================
module dft_frame_enc
    import dft_pkg::*;
(
    input  logic signed [FRAC_W-1:0]     i_fraction,
    output logic                         o_range_err,
    output logic        [FRAME_BITS-1:0] o_frame
);

    localparam int PROD_W = 16 + VALUE_W;

    logic [PROD_W-1:0]          w_prod;
    logic [PROD_W-THR_SHIFT:0]  w_val_wide;
    logic [VALUE_W-1:0]         w_val;
    logic [3:0]                 w_crc;

    assign o_range_err = i_fraction[FRAC_W-1] || (i_fraction[15:0] > THR_FULL);

    assign w_prod     = PROD_W'(i_fraction[15:0]) * PROD_W'(THR_SCALE);
    assign w_val_wide = (PROD_W-THR_SHIFT+1)'(w_prod[PROD_W-1:THR_SHIFT])
                      + (PROD_W-THR_SHIFT+1)'(THR_OFFSET);
    assign w_val      = w_val_wide[VALUE_W-1:0];

    // checksum: XOR of the three upper nibbles; telemetry bit is zero
    assign w_crc   = w_val[10:7] ^ w_val[6:3] ^ {w_val[2:0], 1'b0};
    assign o_frame = {w_val, 1'b0, w_crc};

endmodule

// ===== rtl/dft_wave_gen.sv =====
// ============================================================================
// dft_wave_gen: DShot line waveform state
// Holds active and pending frames and the bit/phase/tick counters; one tick
// per strobe.
// ============================================================================
module dft_wave_gen
    import dft_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_tick,
    input  logic                  i_set,
    input  logic [FRAME_BITS-1:0] i_set_frame,
    input  t_cfg                  i_cfg,
    output t_wave_out             o_next
);

    logic [FRAME_BITS-1:0] r_active, n_active;
    logic [FRAME_BITS-1:0] r_pend,   n_pend;
    logic                  r_pend_v, n_pend_v;
    logic                  r_run,    n_run;
    logic [POS_W-1:0]      r_pos,    n_pos;
    logic                  r_low,    n_low;
    logic [TICK_W-1:0]     r_ticks,  n_ticks;
    logic                  r_pin,    n_pin;
    logic                  w_fend;

    always_comb begin
        n_active = r_active;
        n_pend   = r_pend;
        n_pend_v = r_pend_v;
        n_run    = r_run;
        n_pos    = r_pos;
        n_low    = r_low;
        n_ticks  = r_ticks;
        n_pin    = r_pin;
        w_fend   = 1'b0;
        if (i_set) begin
            n_pend   = i_set_frame;
            n_pend_v = 1'b1;
        end else if (i_tick) begin
            if (!r_run && r_pend_v) begin
                n_active = r_pend;
                n_pend_v = 1'b0;
                n_run    = 1'b1;
                n_pos    = '0;
                n_low    = 1'b0;
                n_ticks  = at_least_one(r_pend[FRAME_BITS-1] ? i_cfg.one_high
                                                             : i_cfg.zero_high);
            end
            if (!n_run) begin
                n_pin = 1'b0;
            end else begin
                n_pin = !n_pos[POS_W-1] && !n_low;
                if (n_ticks != '0) begin
                    n_ticks = n_ticks - TICK_W'(1);
                end
                if (n_ticks == '0) begin
                    if (!n_pos[POS_W-1]) begin
                        if (!n_low) begin
                            n_low   = 1'b1;
                            n_ticks = at_least_one(frame_bit(n_active, n_pos)
                                                   ? i_cfg.one_low : i_cfg.zero_low);
                        end else begin
                            n_pos = n_pos + POS_W'(1);
                            n_low = 1'b0;
                            if (!n_pos[POS_W-1]) begin
                                n_ticks = at_least_one(frame_bit(n_active, n_pos)
                                                       ? i_cfg.one_high : i_cfg.zero_high);
                            end else begin
                                n_ticks = at_least_one(i_cfg.gap);
                            end
                        end
                    end else begin
                        // end of gap: restart, taking a pending frame
                        w_fend = 1'b1;
                        if (n_pend_v) begin
                            n_active = n_pend;
                            n_pend_v = 1'b0;
                        end
                        n_pos   = '0;
                        n_low   = 1'b0;
                        n_ticks = at_least_one(n_active[FRAME_BITS-1] ? i_cfg.one_high
                                                                      : i_cfg.zero_high);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_pend   <= '0;
            r_pend_v <= 1'b0;
            r_run    <= 1'b0;
            r_pos    <= '0;
            r_low    <= 1'b0;
            r_ticks  <= '0;
            r_pin    <= 1'b0;
        end else begin
            r_active <= n_active;
            r_pend   <= n_pend;
            r_pend_v <= n_pend_v;
            r_run    <= n_run;
            r_pos    <= n_pos;
            r_low    <= n_low;
            r_ticks  <= n_ticks;
            r_pin    <= n_pin;
        end
    end

    assign o_next.pin_level  = n_pin;
    assign o_next.frame_word = n_active;
    assign o_next.frame_end  = w_fend;

endmodule

// ===== rtl/dshot_frame_transmitter.sv =====
// ============================================================================
// dshot_frame_transmitter: DShot frame encoder and line waveform generator
// Every command transfer yields one result transfer. A throttle command
// (mode 1) turns a Q1.15 fraction into a pending 16-bit frame, or reports
// status 1 and keeps the frame if the fraction is negative or above 1.0.
// A tick command (mode 0) moves the line waveform one tick: each frame bit,
// MSB first, is high then low for tick counts set by the bit value, then a
// low gap follows and the frame repeats; a pending frame is taken at the next
// frame start. The pin stays low until the first frame is pending. Each
// command passes through the combinational encoder and waveform logic into
// the result register, so a command is taken every cycle while the result
// side keeps up. Tick counts are written through the configuration port
// (index 0..4: one high, one low, zero high, zero low, gap); the user writes
// them only while idle, which the block does not enforce. A zero count acts as one.
// ============================================================================
module dshot_frame_transmitter
    import dft_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    dft_cmd_if.sink               i_cmd,
    dft_res_if.source             o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [TICK_W-1:0]     i_cfg_data
);

    // ---- configuration registers ----
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.one_high  <= TICK_W'(30);
            r_cfg.one_low   <= TICK_W'(10);
            r_cfg.zero_high <= TICK_W'(15);
            r_cfg.zero_low  <= TICK_W'(25);
            r_cfg.gap       <= TICK_W'(500);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ONE_HIGH:  r_cfg.one_high  <= i_cfg_data;
                CFG_ONE_LOW:   r_cfg.one_low   <= i_cfg_data;
                CFG_ZERO_HIGH: r_cfg.zero_high <= i_cfg_data;
                CFG_ZERO_LOW:  r_cfg.zero_low  <= i_cfg_data;
                CFG_GAP:       r_cfg.gap       <= i_cfg_data;
                default: ;     // writes beyond the register list are dropped
            endcase
        end
    end

    // ---- command handshake ----
    // The result register frees up in the same cycle it is drained.
    logic r_out_valid;
    logic w_accept;
    logic w_is_set;

    assign i_cmd.ready = !r_out_valid || o_res.ready;
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign w_is_set    = (i_cmd.mode == MODE_THROTTLE);

    // ---- throttle encoder ----
    logic                  w_range_err;
    logic [FRAME_BITS-1:0] w_frame;

    dft_frame_enc u_enc (
        .i_fraction  (i_cmd.throttle_fraction),
        .o_range_err (w_range_err),
        .o_frame     (w_frame)
    );

    // ---- waveform state ----
    t_wave_out w_wave;

    dft_wave_gen u_wave (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tick      (w_accept && !w_is_set),
        .i_set       (w_accept && w_is_set && !w_range_err),
        .i_set_frame (w_frame),
        .i_cfg       (r_cfg),
        .o_next      (w_wave)
    );

    // ---- result register ----
    t_wave_out r_res;
    logic      r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res    <= w_wave;
            r_status <= (w_is_set && w_range_err) ? STATUS_RANGE : STATUS_OK;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.pin_level  = r_res.pin_level;
    assign o_res.status     = r_status;
    assign o_res.frame_word = r_res.frame_word;
    assign o_res.frame_end  = r_res.frame_end;

`ifndef SYNTHESIS
    // a frame ends only inside the low gap
    a_fend_pin_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.frame_end) |-> !r_res.pin_level)
        else $error("frame end reported with pin high");

    // range errors come from throttle commands, which never end a frame
    a_status_no_fend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status) |-> !r_res.frame_end)
        else $error("range error and frame end in one result");

    // a new result appears only after a command transfer
    a_result_from_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_accept))
        else $error("result without a command transfer");
`endif

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ============================================================================
// testbench: self-checking bench of the DShot frame transmitter
// Feeds tick and throttle commands with random gaps, mirrors the encoder and
// line waveform in a cycle-free predictor, and checks every result transfer
// field by field against the predicted line state, across several
// tick-count settings.
// ============================================================================
module testbench;
    import dft_pkg::*;

    localparam int NUM_REGS    = 5;
    localparam int CYCLE_LIMIT = 300_000;
    localparam int DRAIN_WAIT  = 4;

    typedef struct {
        t_mode                    mode;
        logic signed [FRAC_W-1:0] frac;
        int unsigned              idle;
        bit                       drain_first;   // hold until all results are back
    } t_cmd_item;

    typedef struct {
        logic                  pin_level;
        t_status               status;
        logic [FRAME_BITS-1:0] frame_word;
        logic                  frame_end;
    } t_line_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [TICK_W-1:0]    i_cfg_data;

    dft_cmd_if cmd_ch();
    dft_res_if res_ch();

    dshot_frame_transmitter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd_ch),
        .o_res      (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    t_cmd_item    cmd_pending_q[$];   // commands not yet presented
    t_line_result line_results_q[$];  // predicted results, oldest first
    t_cmd_item    cmd_on_bus;
    int unsigned  mismatches;
    int unsigned  cycles;
    bit           src_calm;
    bit           sink_calm;

    // ------------------------------------------------------------------
    // Predicted line state
    // ------------------------------------------------------------------
    logic [TICK_W-1:0]     tick_regs [0:NUM_REGS-1];
    logic [FRAME_BITS-1:0] m_active;
    logic [FRAME_BITS-1:0] m_pending;
    logic                  m_pend_vld;
    logic                  m_running;
    logic [POS_W-1:0]      m_pos;       // 0..15 frame bit, 16 = gap
    logic                  m_low;
    logic [TICK_W-1:0]     m_left;
    logic                  m_pin;

    // a zero count behaves as a single tick
    function automatic logic [TICK_W-1:0] nonzero_ticks(input logic [TICK_W-1:0] v);
        return (v == '0) ? TICK_W'(1) : v;
    endfunction

    function automatic logic sending_bit();
        int idx;
        idx = FRAME_BITS - 1 - int'(m_pos[BIT_IDX_W-1:0]);
        return m_active[idx];
    endfunction

    function automatic logic [TICK_W-1:0] high_ticks();
        return nonzero_ticks(sending_bit() ? tick_regs[CFG_ONE_HIGH]
                                           : tick_regs[CFG_ZERO_HIGH]);
    endfunction

    // Q1.15 throttle to packed frame; returns 0 when out of range
    function automatic bit encode_throttle(input logic signed [FRAC_W-1:0] frac,
                                           output logic [FRAME_BITS-1:0] frame);
        logic [FRAC_W-1:0]     f;
        int unsigned           val;
        logic [FRAME_BITS-1:0] word;
        logic [3:0]            csum;
        f     = frac;
        frame = '0;
        if (f[FRAC_W-1] || f > FRAC_W'(THR_FULL))
            return 1'b0;
        val   = ((int'(f) * int'(THR_SCALE)) >> THR_SHIFT) + int'(THR_OFFSET);
        word  = {val[VALUE_W-1:0], 5'b0};
        csum  = word[7:4] ^ word[11:8] ^ word[15:12];
        frame = word | FRAME_BITS'(csum);
        return 1'b1;
    endfunction

    task automatic begin_frame();
        if (m_pend_vld) begin
            m_active   = m_pending;
            m_pend_vld = 1'b0;
        end
        m_running = 1'b1;
        m_pos     = '0;
        m_low     = 1'b0;
        m_left    = high_ticks();
    endtask

    // one command through encoder and waveform
    task automatic dshot_line_step(input t_cmd_item c, output t_line_result r);
        logic [FRAME_BITS-1:0] fr;
        r.status    = STATUS_OK;
        r.frame_end = 1'b0;
        if (c.mode == MODE_THROTTLE) begin
            if (encode_throttle(c.frac, fr)) begin
                m_pending  = fr;
                m_pend_vld = 1'b1;
            end else begin
                r.status = STATUS_RANGE;
            end
        end else begin
            if (!m_running && m_pend_vld)
                begin_frame();
            if (!m_running) begin
                m_pin = 1'b0;
            end else begin
                m_pin = (m_pos < FRAME_BITS) && !m_low;
                if (m_left != '0)
                    m_left = m_left - 1'b1;
                if (m_left == '0) begin
                    if (m_pos < FRAME_BITS) begin
                        if (!m_low) begin
                            m_low  = 1'b1;
                            m_left = nonzero_ticks(sending_bit() ? tick_regs[CFG_ONE_LOW]
                                                                 : tick_regs[CFG_ZERO_LOW]);
                        end else begin
                            m_pos = m_pos + 1'b1;
                            m_low = 1'b0;
                            if (m_pos < FRAME_BITS)
                                m_left = high_ticks();
                            else
                                m_left = nonzero_ticks(tick_regs[CFG_GAP]);
                        end
                    end else begin
                        // gap done: frame repeats, pending frame swaps in
                        r.frame_end = 1'b1;
                        begin_frame();
                    end
                end
            end
        end
        r.pin_level  = m_pin;
        r.frame_word = m_active;
    endtask

    // ------------------------------------------------------------------
    // Clock, cycle limit
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Command driver: presents queued commands, predicts on each transfer
    // ------------------------------------------------------------------
    int unsigned idle_left;
    bit          idle_armed;

    always @(posedge i_clk) begin
        t_line_result pred;
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
            idle_armed   = 1'b0;
            idle_left    = 0;
        end else begin
            if (cmd_ch.valid && cmd_ch.ready) begin
                dshot_line_step(cmd_on_bus, pred);
                line_results_q.push_back(pred);
            end
            // slot is free unless a command is still waiting on ready
            if (!cmd_ch.valid || cmd_ch.ready) begin
                if (cmd_pending_q.size() == 0) begin
                    cmd_ch.valid <= 1'b0;
                end else begin
                    if (!idle_armed) begin
                        idle_left  = cmd_pending_q[0].idle;
                        idle_armed = 1'b1;
                    end
                    if (idle_left > 0) begin
                        idle_left--;
                        cmd_ch.valid <= 1'b0;
                    end else if (cmd_pending_q[0].drain_first && line_results_q.size() != 0) begin
                        // pressure: wait for every outstanding result
                        cmd_ch.valid <= 1'b0;
                    end else begin
                        cmd_on_bus = cmd_pending_q.pop_front();
                        idle_armed = 1'b0;
                        cmd_ch.valid             <= 1'b1;
                        cmd_ch.mode              <= cmd_on_bus.mode;
                        cmd_ch.throttle_fraction <= cmd_on_bus.frac;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: random back-pressure, compare against prediction
    // ------------------------------------------------------------------
    int unsigned stall_left;
    int unsigned results_seen;

    always @(posedge i_clk) begin
        t_line_result want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            stall_left   = 0;
            results_seen = 0;
            sink_calm    = 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (line_results_q.size() == 0) begin
                    $error("result transfer with no command outstanding");
                    mismatches++;
                end else begin
                    want = line_results_q.pop_front();
                    if (res_ch.pin_level !== want.pin_level) begin
                        $error("pin_level: expected %0d, actual %0d",
                               want.pin_level, res_ch.pin_level);
                        mismatches++;
                    end
                    if (res_ch.status !== want.status) begin
                        $error("status: expected %0d, actual %0d",
                               want.status, res_ch.status);
                        mismatches++;
                    end
                    if (res_ch.frame_word !== want.frame_word) begin
                        $error("frame_word: expected %h, actual %h",
                               want.frame_word, res_ch.frame_word);
                        mismatches++;
                    end
                    if (res_ch.frame_end !== want.frame_end) begin
                        $error("frame_end: expected %0d, actual %0d",
                               want.frame_end, res_ch.frame_end);
                        mismatches++;
                    end
                end
                results_seen++;
                if (results_seen % 50 == 0)
                    sink_calm = ($urandom_range(0, 3) == 0);
                stall_left = sink_calm ? 0 : $urandom_range(0, 4);
            end
            if (stall_left > 0) begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_cmd(input t_mode mode, input logic signed [FRAC_W-1:0] frac,
                            input bit drain_first);
        t_cmd_item c;
        c.mode        = mode;
        c.frac        = frac;
        c.idle        = src_calm ? 0 : $urandom_range(0, 4);
        c.drain_first = drain_first;
        cmd_pending_q.push_back(c);
    endtask

    // mostly ticks; throttles mostly in range, some out of range
    task automatic random_phase(input int n);
        int unsigned pick;
        logic signed [FRAC_W-1:0] frac;
        for (int k = 0; k < n; k++) begin
            if (k % 40 == 0)
                src_calm = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 86) begin
                frac = FRAC_W'($urandom);
                push_cmd(MODE_TICK, frac, k == n / 2);
            end else begin
                if (pick < 90)
                    frac = ($urandom_range(0, 1) == 1) ? FRAC_W'(THR_FULL) : '0;
                else if (pick < 97)
                    frac = FRAC_W'($urandom_range(0, int'(THR_FULL)));
                else if (pick == 97)
                    frac = FRAC_W'($urandom_range(int'(THR_FULL) + 1, 65535));
                else
                    frac = {1'b1, 16'($urandom)};
                push_cmd(MODE_THROTTLE, frac, k == n / 2);
            end
        end
    endtask

    task automatic wait_drained();
        while (cmd_pending_q.size() != 0 || cmd_ch.valid || line_results_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // writes all five tick counts plus one write to an unused index
    task automatic program_regs(input logic [TICK_W-1:0] one_hi, input logic [TICK_W-1:0] one_lo,
                                input logic [TICK_W-1:0] zero_hi, input logic [TICK_W-1:0] zero_lo,
                                input logic [TICK_W-1:0] gap);
        logic [TICK_W-1:0] vals [0:NUM_REGS-1];
        vals[CFG_ONE_HIGH]  = one_hi;
        vals[CFG_ONE_LOW]   = one_lo;
        vals[CFG_ZERO_HIGH] = zero_hi;
        vals[CFG_ZERO_LOW]  = zero_lo;
        vals[CFG_GAP]       = gap;
        for (int r = 0; r < NUM_REGS; r++) begin
            @(posedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= t_cfg_idx'(r);
            i_cfg_data <= vals[r];
            tick_regs[r] = vals[r];
        end
        // index past the register list: must be ignored
        @(posedge i_clk);
        i_cfg_idx  <= CFG_IDX_W'(CFG_GAP) + CFG_IDX_W'($urandom_range(1, 3));
        i_cfg_data <= TICK_W'($urandom);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [TICK_W-1:0] short_count(input int hi);
        return TICK_W'($urandom_range(1, hi));
    endfunction

    initial begin
        // known levels from time zero
        i_rst_n                  = 1'b0;
        i_cfg_we                 = 1'b0;
        i_cfg_idx                = '0;
        i_cfg_data               = '0;
        cmd_ch.valid             = 1'b0;
        cmd_ch.mode              = MODE_TICK;
        cmd_ch.throttle_fraction = '0;
        res_ch.ready             = 1'b0;
        mismatches               = 0;
        cycles                   = 0;
        src_calm                 = 1'b0;

        tick_regs[CFG_ONE_HIGH]  = 15'd30;
        tick_regs[CFG_ONE_LOW]   = 15'd10;
        tick_regs[CFG_ZERO_HIGH] = 15'd15;
        tick_regs[CFG_ZERO_LOW]  = 15'd25;
        tick_regs[CFG_GAP]       = 15'd500;
        m_active   = '0;
        m_pending  = '0;
        m_pend_vld = 1'b0;
        m_running  = 1'b0;
        m_pos      = '0;
        m_low      = 1'b0;
        m_left     = '0;
        m_pin      = 1'b0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: idle line, range limits, pending frame replacement
        @(negedge i_clk);
        push_cmd(MODE_TICK, '0, 1'b0);
        push_cmd(MODE_TICK, {FRAC_W{1'b1}}, 1'b0);
        push_cmd(MODE_TICK, '0, 1'b0);
        push_cmd(MODE_THROTTLE, -17'sd65536, 1'b0);   // most negative
        push_cmd(MODE_TICK, '0, 1'b0);
        push_cmd(MODE_THROTTLE, 17'sd65535, 1'b0);    // largest positive
        push_cmd(MODE_THROTTLE, 17'sd32769, 1'b0);    // just above 1.0
        push_cmd(MODE_THROTTLE, -17'sd1, 1'b0);
        push_cmd(MODE_TICK, '0, 1'b0);                // still no frame
        push_cmd(MODE_THROTTLE, 17'sd32768, 1'b0);    // full scale
        push_cmd(MODE_THROTTLE, 17'sd0, 1'b0);        // replaces pending
        push_cmd(MODE_THROTTLE, 17'sd1, 1'b0);
        push_cmd(MODE_THROTTLE, 17'sd32767, 1'b0);
        push_cmd(MODE_THROTTLE, 17'sd16384, 1'b0);
        for (int k = 0; k < 6; k++)
            push_cmd(MODE_TICK, FRAC_W'($urandom), 1'b0);
        push_cmd(MODE_THROTTLE, 17'sd32768, 1'b0);    // pending mid-frame
        push_cmd(MODE_TICK, '0, 1'b0);
        wait_drained();

        // shortest counts: many frames, pending swaps at frame start
        program_regs(15'd1, 15'd1, 15'd1, 15'd1, 15'd1);
        @(negedge i_clk);
        random_phase(250);
        wait_drained();

        // zero counts act as one
        program_regs('0, '0, '0, '0, '0);
        @(negedge i_clk);
        random_phase(250);
        wait_drained();

        program_regs(short_count(6), short_count(6), short_count(6),
                     short_count(6), short_count(6));
        @(negedge i_clk);
        random_phase(400);
        wait_drained();

        // largest counts on some parts of the waveform
        program_regs(15'd32767, 15'd1, 15'd2, 15'd32767, 15'd3);
        @(negedge i_clk);
        random_phase(150);
        wait_drained();

        program_regs(15'd2, 15'd32767, 15'd3, 15'd1, 15'd32767);
        @(negedge i_clk);
        random_phase(100);
        wait_drained();

        program_regs(short_count(8), short_count(8), short_count(8),
                     short_count(8), short_count(8));
        @(negedge i_clk);
        random_phase(500);
        wait_drained();

        program_regs(15'd30, 15'd10, 15'd15, 15'd25, 15'd500);
        @(negedge i_clk);
        random_phase(150);
        wait_drained();

        if (mismatches == 0 && line_results_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
